@@ rtl/lamport_request_queue_defines.svh @@
// assertion macros for the lamport request queue
`ifndef LAMPORT_REQUEST_QUEUE_DEFINES_SVH
`define LAMPORT_REQUEST_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk while out of reset
`define LRQ_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrq check failed");
// next-cycle implication
`define LRQ_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrq check failed");
`else
`define LRQ_ASSERT_IMPL(name, ante, cons)
`define LRQ_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/lrq_pkg.sv @@
// shared constants, types and helpers of the lamport request queue
package lrq_pkg;

	localparam int NODES       = 16;
	localparam int ADDR_W      = $clog2(NODES);
	localparam int CNT_W       = $clog2(NODES + 1);

	localparam int STAMP_W     = 32;
	localparam int NODE_W      = 4;
	localparam int AMOUNT_W    = 16;
	localparam int OP_W        = 2;
	localparam int OUTCOME_W   = 2;
	localparam int SUM_AHEAD_W = 20;
	localparam int OCC_W       = 5;
	localparam int CAPACITY_W  = 16;

	// exact running sum never exceeds NODES * max amount
	localparam int SUM_W       = AMOUNT_W + $clog2(NODES);
	localparam int SUM_EXT_W   = (SUM_W > SUM_AHEAD_W) ? SUM_W : SUM_AHEAD_W;
	localparam logic [SUM_AHEAD_W-1:0] SUM_MAX = {SUM_AHEAD_W{1'b1}};

	localparam int IN_DATA_W   = 56;
	localparam int IN_USER_W   = OP_W;
	localparam int OUT_DATA_W  = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic [OUTCOME_W-1:0] OUT_OK       = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_FULL     = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_NOTFOUND = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

	localparam logic [CAPACITY_W-1:0] CAPACITY_RST = 16'd1;

	// stamp in the low bits, matching the input word layout
	typedef struct packed {
		logic [AMOUNT_W-1:0] amount;
		logic [NODE_W-1:0]   node;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [OUT_DATA_W-30-1:0] pad;
		logic [OCC_W-1:0]         occupancy;
		logic                     admitted;
		logic [SUM_AHEAD_W-1:0]   sum_ahead;
		logic                     own_at_head;
		logic                     own_present;
		logic [OUTCOME_W-1:0]     outcome;
	} out_word_t;

	// held entry sorts after the incoming one
	function automatic logic goes_before(entry_t held, entry_t ins);
		return (held.stamp > ins.stamp) ||
			((held.stamp == ins.stamp) && (held.node > ins.node));
	endfunction

endpackage

@@ rtl/lrq_ram.sv @@
// generic single-write, single-read ram with registered read data
module lrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/lamport_request_queue.sv @@
// top level of the lamport request queue: sequencer around the entry ram
//
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     s_tdata: stamp, origin_node, amount; s_tuser: op
// m_*       out  m_tvalid / m_tready     m_tdata: outcome .. occupancy
// cfg_*     in   cfg_valid / cfg_ready   cfg_index, cfg_data (own_id, capacity)
//
// one word at a time: a sorted insert walks down the ram shifting later
// entries up, a removal walks up shifting later entries down, and a query
// leaves the table alone; every word then ends in a scan that sums amounts
// until the own entry, one ram read a cycle
// a finished result waits in the output register; the next word is taken
// meanwhile, and the sequencer only holds in its last state if that register
// is still full. reset clears the count and sets the config to own_id 0 and
// capacity 1, the ram needs no clearing
`include "lamport_request_queue_defines.svh"

module lamport_request_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [31:0] stamp, [35:32] origin_node, [51:36] amount, [55:52] zero
	input  logic [lrq_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] op
	input  logic [lrq_pkg::IN_USER_W-1:0]    s_tuser,
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [1:0] outcome, [2] own_present, [3] own_at_head, [23:4] sum_ahead,
	// [24] admitted, [29:25] occupancy, [31:30] zero
	output logic [lrq_pkg::OUT_DATA_W-1:0]   m_tdata,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lrq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lrq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = lrq_pkg::CNT_W;
	localparam int AW = lrq_pkg::ADDR_W;
	localparam int SW = lrq_pkg::SUM_W;
	localparam int XW = lrq_pkg::SUM_EXT_W;

	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] NODES_C = CW'(lrq_pkg::NODES);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_REM  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// config registers
	logic [lrq_pkg::NODE_W-1:0]     own_id_q;
	logic [lrq_pkg::CAPACITY_W-1:0] capacity_q;

	// control state
	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] hole_q, hole_d;     // free slot during the insert walk
	logic [CW-1:0] rd_q, rd_d;         // read pointer of the current walk
	logic          found_q, found_d;
	logic          hit_q, hit_d;
	logic          at_head_q, at_head_d;
	logic          admitted_q, admitted_d;
	logic [SW-1:0] sum_q, sum_d;
	logic [lrq_pkg::OUTCOME_W-1:0] outcome_q, outcome_d;
	logic          m_tvalid_q;

	// read pipeline tag: which entry the ram output holds
	logic          rv_s1;
	logic [CW-1:0] idx_s1;

	// item and result payload
	lrq_pkg::entry_t    new_q;
	lrq_pkg::out_word_t out_q;

	// ram ports
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [lrq_pkg::ENTRY_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [lrq_pkg::ENTRY_W-1:0] ram_rdata;
	lrq_pkg::entry_t             rd_entry;

	logic          leave;
	logic          out_load;
	logic          last_s1;
	logic [SW:0]   own_total;
	logic [XW-1:0] sum_ext;
	logic [lrq_pkg::SUM_AHEAD_W-1:0] sum_sat;

	lrq_ram #(
		.WIDTH (lrq_pkg::ENTRY_W),
		.DEPTH (lrq_pkg::NODES)
	) u_entries (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign rd_entry  = lrq_pkg::entry_t'(ram_rdata);
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;

	assign last_s1   = (idx_s1 == count_q - ONE_C);
	assign own_total = {1'b0, sum_q} + (SW + 1)'(rd_entry.amount);

	// sum_ahead saturates when the exact sum outgrows the field
	assign sum_ext = XW'(sum_q);
	assign sum_sat = (sum_ext > XW'(lrq_pkg::SUM_MAX)) ? lrq_pkg::SUM_MAX :
		sum_ext[lrq_pkg::SUM_AHEAD_W-1:0];

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		hole_d     = hole_q;
		rd_d       = rd_q;
		found_d    = found_q;
		hit_d      = hit_q;
		at_head_d  = at_head_q;
		admitted_d = admitted_q;
		sum_d      = sum_q;
		outcome_d  = outcome_q;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = new_q;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		leave      = 1'b0;
		out_load   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					// scan results start clean for every word
					hit_d      = 1'b0;
					at_head_d  = 1'b0;
					admitted_d = 1'b0;
					sum_d      = '0;
					found_d    = 1'b0;
					rd_d       = '0;
					outcome_d  = lrq_pkg::OUT_OK;
					case (s_tuser)
						lrq_pkg::OP_INSERT: begin
							if (count_q == NODES_C) begin
								outcome_d = lrq_pkg::OUT_FULL;
								state_d   = ST_SCAN;
							end else begin
								hole_d  = count_q;
								rd_d    = count_q;
								state_d = ST_INS;
							end
						end
						lrq_pkg::OP_REMOVE: begin
							if (count_q == '0) begin
								outcome_d = lrq_pkg::OUT_NOTFOUND;
								state_d   = ST_SCAN;
							end else begin
								state_d = ST_REM;
							end
						end
						default: begin
							// query and the unused code leave the table alone
							state_d = ST_SCAN;
						end
					endcase
				end
			end

			ST_INS: begin
				// walk down from the top, moving later entries up one slot
				ram_re    = (rd_q != '0);
				ram_raddr = AW'(rd_q - ONE_C);
				if (ram_re) begin
					rd_d = rd_q - ONE_C;
				end
				if (hole_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = new_q;
					leave     = 1'b1;
				end else if (rv_s1) begin
					ram_we    = 1'b1;
					ram_waddr = hole_q[AW-1:0];
					if (lrq_pkg::goes_before(rd_entry, new_q)) begin
						ram_wdata = rd_entry;
						hole_d    = hole_q - ONE_C;
					end else begin
						ram_wdata = new_q;
						leave     = 1'b1;
					end
				end
				if (leave) begin
					count_d = count_q + ONE_C;
					rd_d    = '0;
					state_d = ST_SCAN;
				end
			end

			ST_REM: begin
				// walk up; once the node is found, pull each later entry down
				ram_re    = (rd_q < count_q);
				ram_raddr = rd_q[AW-1:0];
				if (ram_re) begin
					rd_d = rd_q + ONE_C;
				end
				if (rv_s1) begin
					if (found_q) begin
						ram_we    = 1'b1;
						ram_waddr = AW'(idx_s1 - ONE_C);
						ram_wdata = rd_entry;
					end else if (rd_entry.node == new_q.node) begin
						found_d = 1'b1;
					end
					if (last_s1) begin
						leave = 1'b1;
						rd_d  = '0;
						if (found_d) begin
							count_d = count_q - ONE_C;
						end else begin
							outcome_d = lrq_pkg::OUT_NOTFOUND;
						end
						state_d = ST_SCAN;
					end
				end
			end

			ST_SCAN: begin
				// sum amounts ahead of the first own entry
				ram_re    = (rd_q < count_q);
				ram_raddr = rd_q[AW-1:0];
				if (ram_re) begin
					rd_d = rd_q + ONE_C;
				end
				if (count_q == '0) begin
					leave = 1'b1;
				end else if (rv_s1) begin
					if (rd_entry.node == own_id_q) begin
						hit_d      = 1'b1;
						at_head_d  = (idx_s1 == '0);
						admitted_d = (own_total <= (SW + 1)'(capacity_q));
						leave      = 1'b1;
					end else begin
						sum_d = sum_q + SW'(rd_entry.amount);
						leave = last_s1;
					end
				end
				if (leave) begin
					state_d = ST_FIN;
				end
			end

			ST_FIN: begin
				// wait here only while the previous result is still unread
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			hole_q     <= '0;
			rd_q       <= '0;
			found_q    <= 1'b0;
			hit_q      <= 1'b0;
			at_head_q  <= 1'b0;
			admitted_q <= 1'b0;
			sum_q      <= '0;
			outcome_q  <= lrq_pkg::OUT_OK;
			rv_s1      <= 1'b0;
			idx_s1     <= '0;
			m_tvalid_q <= 1'b0;
			own_id_q   <= '0;
			capacity_q <= lrq_pkg::CAPACITY_RST;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			hole_q     <= hole_d;
			rd_q       <= rd_d;
			found_q    <= found_d;
			hit_q      <= hit_d;
			at_head_q  <= at_head_d;
			admitted_q <= admitted_d;
			sum_q      <= sum_d;
			outcome_q  <= outcome_d;
			// a read issued while leaving a walk belongs to nobody
			rv_s1      <= ram_re && !leave;
			idx_s1     <= CW'(ram_raddr);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					lrq_pkg::REG_OWN_ID: begin
						own_id_q <= cfg_data[lrq_pkg::NODE_W-1:0];
					end
					lrq_pkg::REG_CAPACITY: begin
						capacity_q <= cfg_data[lrq_pkg::CAPACITY_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			new_q <= lrq_pkg::entry_t'(s_tdata[lrq_pkg::ENTRY_W-1:0]);
		end
		if (out_load) begin
			out_q.pad         <= '0;
			out_q.occupancy   <= lrq_pkg::OCC_W'(count_q);
			out_q.admitted    <= hit_q && admitted_q;
			out_q.sum_ahead   <= hit_q ? sum_sat : '0;
			out_q.own_at_head <= hit_q && at_head_q;
			out_q.own_present <= hit_q;
			out_q.outcome     <= outcome_q;
		end
	end

	`LRQ_ASSERT_IMPL(a_count_range, 1'b1, count_q <= NODES_C)
	`LRQ_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q != ST_IDLE)
	`LRQ_ASSERT_IMPL(a_full_flag, out_load && outcome_q == lrq_pkg::OUT_FULL, count_q == NODES_C)
	`LRQ_ASSERT_IMPL(a_write_phase, ram_we, state_q == ST_INS || state_q == ST_REM)

endmodule

@@ bench/lamport_request_queue_tb.sv @@
// self-checking bench for the lamport request queue: sorted inserts, removals and admission
module lamport_request_queue_tb;
	import lrq_pkg::*;

	// op code the block treats as a plain query
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 215;
	// an insert into a table of 15 is slow, keep a wide margin
	localparam int TAIL_CYCLES   = 60;
	localparam int MAX_PRINTS    = 60;
	// results after which the receiver stops draining for a long stretch
	localparam int HOLD_AT_A     = 250;
	localparam int HOLD_AT_B     = 800;
	localparam int HOLD_CYCLES   = 600;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [STAMP_W-1:0]  stamp;
		logic [NODE_W-1:0]   node;
		logic [AMOUNT_W-1:0] amount;
	} request_t;

	// mix of the random stimulus over a window of requests
	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} load_mix_t;

	// receiver behavior between long holds
	typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_BUSY} rx_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [IN_USER_W-1:0]  s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predicted table, kept in sorted order, and the register copies
	entry_t                held_req [NODES];
	int unsigned           held_cnt  = 0;
	logic [NODE_W-1:0]     own_node  = '0;
	logic [CAPACITY_W-1:0] cap_units = CAPACITY_RST;

	// requests waiting to be sent and status words waiting to come back
	request_t              req_backlog [$];
	out_word_t             status_due [$];

	// rough occupancy per node, used only to steer the stimulus
	int unsigned           node_held [NODES];
	int unsigned           held_total = 0;

	// sender state
	request_t              offered;
	out_word_t             next_status;
	int unsigned           burst_left = 0;
	int unsigned           gap_left   = 0;

	// receiver state
	rx_mode_t              rx_mode    = RX_OPEN;
	int unsigned           mode_left  = 0;
	int unsigned           hold_left  = 0;
	int unsigned           words_drained = 0;

	// monitor state
	out_word_t             seen_status;
	out_word_t             want_status;

	int unsigned           items_loaded   = 0;
	int unsigned           items_taken    = 0;
	int unsigned           words_checked  = 0;
	int unsigned           mismatches     = 0;
	int unsigned           full_drops     = 0;
	int unsigned           absent_removes = 0;
	int unsigned           admits         = 0;
	int unsigned           reg_writes     = 0;

	lamport_request_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// applies one request to the predicted table and returns the status word it yields
	function automatic out_word_t status_after(request_t r);
		out_word_t   res;
		int unsigned pos;
		int unsigned k;
		int unsigned sum;
		res = '0;
		res.outcome = OUT_OK;
		pos = 0;
		if (r.op == OP_INSERT) begin
			if (held_cnt >= NODES) begin
				res.outcome = OUT_FULL;
			end else begin
				// skip entries that stay ahead: lower stamp, or same stamp and node not above
				while (pos < held_cnt && !(held_req[pos].stamp > r.stamp ||
						(held_req[pos].stamp == r.stamp && held_req[pos].node > r.node)))
					pos++;
				for (k = held_cnt; k > pos; k--)
					held_req[k] = held_req[k - 1];
				held_req[pos].stamp  = r.stamp;
				held_req[pos].node   = r.node;
				held_req[pos].amount = r.amount;
				held_cnt++;
			end
		end else if (r.op == OP_REMOVE) begin
			// only the first entry of that node goes
			while (pos < held_cnt && held_req[pos].node != r.node)
				pos++;
			if (pos >= held_cnt) begin
				res.outcome = OUT_NOTFOUND;
			end else begin
				for (k = pos; k + 1 < held_cnt; k++)
					held_req[k] = held_req[k + 1];
				held_cnt--;
			end
		end
		// amounts ahead of the own entry
		pos = 0;
		sum = 0;
		while (pos < held_cnt && held_req[pos].node != own_node) begin
			sum += held_req[pos].amount;
			pos++;
		end
		if (pos < held_cnt) begin
			res.own_present = 1'b1;
			res.own_at_head = (pos == 0);
			res.admitted    = (sum + held_req[pos].amount <= cap_units);
			res.sum_ahead   = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_AHEAD_W-1:0];
		end
		res.occupancy = held_cnt[OCC_W-1:0];
		return res;
	endfunction

	function automatic request_t make_req(logic [OP_W-1:0] op, logic [STAMP_W-1:0] stamp,
			logic [NODE_W-1:0] node, logic [AMOUNT_W-1:0] amount);
		request_t r;
		r.op     = op;
		r.stamp  = stamp;
		r.node   = node;
		r.amount = amount;
		return r;
	endfunction

	// small stamps give plenty of ties, plus the two ends of the range
	function automatic logic [STAMP_W-1:0] pick_stamp();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return STAMP_W'($urandom_range(0, 15));
		if (roll == 4)
			return ($urandom_range(0, 1) == 1) ? {STAMP_W{1'b1}} : '0;
		return $urandom();
	endfunction

	// small amounts make admission flip around moderate capacities
	function automatic logic [AMOUNT_W-1:0] pick_amount();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 8)
			return AMOUNT_W'($urandom_range(0, 8));
		if (roll < 11)
			return ($urandom_range(0, 1) == 1) ? {AMOUNT_W{1'b1}} : '0;
		return AMOUNT_W'($urandom_range(0, 65535));
	endfunction

	function automatic void queue_item(request_t r);
		req_backlog = {req_backlog, r};
		items_loaded++;
		if (r.op == OP_INSERT && held_total < NODES) begin
			node_held[r.node]++;
			held_total++;
		end else if (r.op == OP_REMOVE && node_held[r.node] > 0) begin
			node_held[r.node]--;
			held_total--;
		end
	endfunction

	task automatic flag(input string what);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at status word %0d: %s", words_checked, what);
		mismatches++;
	endtask

	// register write, only issued while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_OWN_ID)
			own_node = val[NODE_W-1:0];
		else
			cap_units = val;
		reg_writes++;
	endtask

	// every request sent and every status word back
	task automatic wait_idle();
		while (items_taken != items_loaded || status_due.size() != 0)
			@(posedge clk);
	endtask

	// sender: bursts of random length, random gaps, predicts on each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				next_status = status_after(offered);
				status_due = {status_due, next_status};
				items_taken++;
				if (next_status.outcome == OUT_FULL)
					full_drops++;
				if (next_status.outcome == OUT_NOTFOUND)
					absent_removes++;
				if (next_status.admitted)
					admits++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					offered = req_backlog.pop_front();
					s_tdata  <= {{(IN_DATA_W - 52){1'b0}}, offered.amount, offered.node,
						offered.stamp};
					s_tuser  <= offered.op;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// new burst; a quarter of them follow on with no gap at all
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: changing stall pattern, plus two long holds that back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				words_drained++;
				if (words_drained == HOLD_AT_A || words_drained == HOLD_AT_B)
					hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// monitor: every status word against the oldest prediction, field by field
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_status = out_word_t'(m_tdata);
			if (status_due.size() == 0) begin
				flag("status word with no request waiting");
			end else begin
				want_status = status_due.pop_front();
				if (seen_status.outcome !== want_status.outcome)
					flag($sformatf("outcome got %0d want %0d", seen_status.outcome,
						want_status.outcome));
				if (seen_status.own_present !== want_status.own_present)
					flag($sformatf("own_present got %0b want %0b", seen_status.own_present,
						want_status.own_present));
				if (seen_status.own_at_head !== want_status.own_at_head)
					flag($sformatf("own_at_head got %0b want %0b", seen_status.own_at_head,
						want_status.own_at_head));
				if (seen_status.sum_ahead !== want_status.sum_ahead)
					flag($sformatf("sum_ahead got %0d want %0d", seen_status.sum_ahead,
						want_status.sum_ahead));
				if (seen_status.admitted !== want_status.admitted)
					flag($sformatf("admitted got %0b want %0b", seen_status.admitted,
						want_status.admitted));
				if (seen_status.occupancy !== want_status.occupancy)
					flag($sformatf("occupancy got %0d want %0d", seen_status.occupancy,
						want_status.occupancy));
			end
			words_checked++;
		end
	end

	initial begin : stimulus
		request_t              r;
		load_mix_t             mix;
		int unsigned           roll;
		int unsigned           ins_limit;
		logic [NODE_W-1:0]     pick;
		logic [NODE_W-1:0]     phase_own [RANDOM_PHASES];
		logic [CAPACITY_W-1:0] phase_cap [RANDOM_PHASES];

		foreach (node_held[n])
			node_held[n] = 0;
		// register settings per phase: both ends of each range among them
		phase_own = '{4'd15, 4'd0, 4'd7, NODE_W'($urandom_range(0, 15)), 4'd3};
		phase_cap = '{16'hFFFF, 16'd0, 16'd20, CAPACITY_W'($urandom_range(2, 65534)), 16'd100};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, run with the reset settings: own node 0, capacity 1
		// empty table: query, remove of an absent node, the spare op code
		queue_item(make_req(OP_QUERY, '0, 4'd0, '0));
		queue_item(make_req(OP_REMOVE, 32'd7, 4'd5, 16'd3));
		queue_item(make_req(OP_SPARE, {STAMP_W{1'b1}}, 4'd15, {AMOUNT_W{1'b1}}));
		// another node only, so no own entry
		queue_item(make_req(OP_INSERT, 32'd10, 4'd3, 16'd1));
		// same stamp, lower node sorts first: own entry lands at the head
		queue_item(make_req(OP_INSERT, 32'd10, 4'd0, 16'd0));
		// same stamp and node goes behind the one already held
		queue_item(make_req(OP_INSERT, 32'd10, 4'd0, 16'd5));
		// ends of the stamp and amount ranges
		queue_item(make_req(OP_INSERT, '0, 4'd9, {AMOUNT_W{1'b1}}));
		queue_item(make_req(OP_INSERT, {STAMP_W{1'b1}}, 4'd15, {AMOUNT_W{1'b1}}));
		queue_item(make_req(OP_INSERT, 32'd10, 4'd15, 16'd2));
		queue_item(make_req(OP_REMOVE, '0, 4'd9, '0));
		// removes the first own entry, the second one stays and is over capacity
		queue_item(make_req(OP_REMOVE, '0, 4'd0, '0));
		// fill the table to the top, then one insert that gets dropped
		for (int i = 0; i < 12; i++)
			queue_item(make_req(OP_INSERT, pick_stamp(), NODE_W'(i), pick_amount()));
		queue_item(make_req(OP_INSERT, 32'd5, 4'd1, 16'd1));
		queue_item(make_req(OP_QUERY, '0, 4'd0, '0));
		wait_idle();

		// random part, one register setting per phase
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(REG_OWN_ID, CFG_DATA_W'(phase_own[ph]));
			write_reg(REG_CAPACITY, phase_cap[ph]);
			mix = MIX_EVEN;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// windows that fill the table up to full or drain it to empty
				if (i % 40 == 0)
					mix = load_mix_t'($urandom_range(0, 2));
				case (mix)
					MIX_FILL:  ins_limit = 70;
					MIX_DRAIN: ins_limit = 20;
					default:   ins_limit = 45;
				endcase
				roll     = $urandom_range(0, 99);
				r.stamp  = pick_stamp();
				r.amount = pick_amount();
				r.node   = ($urandom_range(0, 9) < 3) ? own_node : NODE_W'($urandom_range(0, 15));
				if (roll < ins_limit) begin
					r.op = OP_INSERT;
				end else if (roll < 85) begin
					r.op = OP_REMOVE;
					// mostly a node that is held, otherwise whatever came up
					if (held_total > 0 && $urandom_range(0, 4) != 0) begin
						do pick = NODE_W'($urandom_range(0, 15)); while (node_held[pick] == 0);
						r.node = pick;
					end
				end else begin
					r.op = (roll >= 97) ? OP_SPARE : OP_QUERY;
				end
				queue_item(r);
			end
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d requests under %0d register writes, %0d status words checked",
			items_taken, reg_writes, words_checked);
		$display("inserts dropped on a full table %0d, removes of absent nodes %0d, admitted %0d",
			full_drops, absent_removes, admits);
		if (mismatches == 0 && status_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#5000000;
		$display("timeout with %0d status words still due", status_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
